@@ hdl/psrle_pkg.sv @@
// psrle_pkg: types and constants shared by the plotter run-length encoder.
// Used by psrle_emit and plotter_step_run_length_encoder; depends on nothing.
`default_nettype none

package psrle_pkg;

   localparam int CSR_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X_LIMIT    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_X    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_TICKS = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PEN_TICKS  = 2'd3;

   localparam logic [14:0] X_LIMIT_RESET    = 15'd4096;
   localparam logic [15:0] START_X_RESET    = 16'd0;
   localparam logic [15:0] STEP_TICKS_RESET = 16'd100;
   localparam logic [15:0] PEN_TICKS_RESET  = 16'd1000;

   localparam logic [3:0] DIR_NONE     = 4'd0;
   localparam logic [3:0] DIR_PEN_DOWN = 4'd12;
   localparam logic [3:0] DIR_PEN_UP   = 4'd14;

   // skip test selects (device bits 8..6)
   localparam logic [2:0] TST_IDLE      = 3'b001;
   localparam logic [2:0] TST_NOT_LIMIT = 3'b010;
   localparam logic [2:0] TST_NO_IRQ    = 3'b100;

   typedef enum logic [2:0] {
      OP_MOVE  = 3'd0,
      OP_SKIP  = 3'd1,
      OP_MASK  = 3'd2,
      OP_TICK  = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      PH_LIMIT   = 3'b001,
      PH_UNLIMIT = 3'b010,
      PH_SHOW    = 3'b100
   } phase_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic [9:0] device_bits;
      logic       mask_bit;
   } req_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] plot_byte;
      logic       last;
      logic       skip_result;
      logic       interrupt_request;
      logic       error_flag;
   } rsp_type;

   // status carried unchanged on every beat of one command
   typedef struct packed {
      logic skip;
      logic irq;
      logic err;
   } status_type;

endpackage

`default_nettype wire

@@ hdl/psrle_emit.sv @@
// psrle_emit: result register and byte serialiser for one flushed run.
// Depends on psrle_pkg.
`default_nettype none

module psrle_emit #(
   parameter int COUNT_BITS = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   ld,
   input  wire logic                   ld_has_bytes,
   input  wire logic [COUNT_BITS-1:0]  ld_cnt,
   input  wire logic [3:0]             ld_dir,
   input  wire psrle_pkg::status_type  ld_status,
   output logic                        ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output psrle_pkg::rsp_type          rsp_data
);
   import psrle_pkg::*;

   // 7-bit prefix groups above the low three count bits
   localparam int NG = (COUNT_BITS - 3 + 6) / 7;
   localparam int EW = 7 * NG + 4;
   localparam int PW = $clog2(NG + 1);

   logic                  valid_ff;
   logic                  has_ff;
   logic [PW-1:0]         pre_ff;
   logic [COUNT_BITS-1:0] cnt_ff;
   logic [3:0]            dir_ff;
   status_type            st_ff;

   logic [EW-1:0] ld_ext;
   logic [EW-1:0] cur_ext;
   logic [PW-1:0] ld_pre;
   logic [6:0]    sel;
   logic          last_beat;
   logic          take;

   assign ld_ext  = EW'(ld_cnt);
   assign cur_ext = EW'(cnt_ff);

   always_comb begin
      ld_pre = '0;
      sel    = '0;
      for (int j = 0; j < NG; j++) begin
         if (ld_ext[3 + 7 * j +: 7] != 7'd0) begin
            ld_pre = PW'(j + 1);
         end
         if (pre_ff == PW'(j + 1)) begin
            sel = cur_ext[3 + 7 * j +: 7];
         end
      end
   end

   assign last_beat = !has_ff || (pre_ff == '0);
   assign take      = valid_ff && !rsp_stall;
   assign ready     = !valid_ff || (take && last_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ld) begin
         valid_ff <= 1'b1;
      end else if (take && last_beat) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         has_ff <= ld_has_bytes;
         pre_ff <= ld_pre;
         cnt_ff <= ld_cnt;
         dir_ff <= ld_dir;
         st_ff  <= ld_status;
      end else if (take && !last_beat) begin
         pre_ff <= pre_ff - PW'(1);
      end
   end

   assign rsp_valid = valid_ff;

   always_comb begin
      rsp_data.byte_valid        = has_ff;
      rsp_data.last              = last_beat;
      rsp_data.skip_result       = st_ff.skip;
      rsp_data.interrupt_request = st_ff.irq;
      rsp_data.error_flag        = st_ff.err;
      if (!has_ff) begin
         rsp_data.plot_byte = 8'd0;
      end else if (pre_ff != '0) begin
         rsp_data.plot_byte = {1'b1, sel};
      end else begin
         rsp_data.plot_byte = {1'b0, dir_ff, cnt_ff[2:0]};
      end
   end

`ifndef SYNTH
   // a taken prefix beat is always followed by another byte of the same run
   a_prefix_continues: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_stall && !last_beat) |=> (valid_ff && has_ff))
      else $error("prefix beat not followed by a byte");

   a_pre_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (pre_ff <= PW'(NG)))
      else $error("prefix count out of range");

   a_no_load_when_busy: assert property (@(posedge clock) disable iff (reset)
      ld |-> ready)
      else $error("load while a beat is still owed");
`endif

endmodule

`default_nettype wire

@@ hdl/plotter_step_run_length_encoder.sv @@
// plotter_step_run_length_encoder: top level of the incremental plotter controller.
// Depends on psrle_pkg and psrle_emit.
`default_nettype none

// A command is taken, and all controller state updated, in the cycle it is accepted; its
// results are held in an output register and sent one beat a cycle while rsp_stall is
// low. A command that flushes no run gives a single beat, so such commands run at one
// per cycle while rsp_stall is low. A flushed run gives one beat per 7-bit prefix group
// up to the highest nonzero one, plus the direction/count byte, 1 to (COUNT_BITS + 3) / 7
// + 1 beats (4 at COUNT_BITS 18 to 24, 5 at 25 to 31), and the next command is taken in
// the cycle its last beat leaves. The emitter register is the only thing that sets this.
// The x position resets to the reset value of start_x; later writes to start_x have no effect.
module plotter_step_run_length_encoder #(
   parameter int COUNT_BITS = 24
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire psrle_pkg::req_type                    req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output psrle_pkg::rsp_type                         rsp_data,
   input  wire logic                                  csr_wr_en,
   input  wire logic [psrle_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [psrle_pkg::CSR_WIDTH-1:0]       csr_wdata
);
   import psrle_pkg::*;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   logic [14:0]           x_limit_ff;
   logic [15:0]           step_ticks_ff;
   logic [15:0]           pen_ticks_ff;

   logic [15:0]           x_ff, x_in;
   phase_type             phase_ff, phase_in;
   logic [3:0]            dir_ff, dir_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                  idle_ff, idle_in;
   logic                  irq_ff, irq_in;
   logic [15:0]           busy_ff, busy_in;

   logic       accept;
   logic       emit_ready;
   logic [3:0] d;
   logic       pen;
   logic       legal;
   logic       cur_limit;
   logic       new_limit;
   logic [15:0] x_mv;
   phase_type  phase_eff;
   logic       flush;
   logic       skip;
   logic       err;
   status_type status;

   function automatic logic at_limit(input logic [15:0] x, input logic [14:0] lim);
      return x[15] || (x[14:0] >= lim);
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = !emit_ready;

   assign d     = req_data.device_bits[9:6];
   assign pen   = (d == DIR_PEN_DOWN) || (d == DIR_PEN_UP);
   assign legal = pen || ((d != DIR_NONE) && (d[1:0] != 2'b11) && (d[3:2] != 2'b11));

   always_comb begin
      if (pen) begin
         x_mv = x_ff;
      end else if (d[0]) begin
         x_mv = x_ff + 16'd1;
      end else if (d[1]) begin
         x_mv = x_ff - 16'd1;
      end else begin
         x_mv = x_ff;
      end
   end

   assign cur_limit = at_limit(x_ff, x_limit_ff);
   assign new_limit = at_limit(x_mv, x_limit_ff);
   assign phase_eff = (d == DIR_PEN_DOWN) ? PH_SHOW : phase_ff;

   always_comb begin
      x_in     = x_ff;
      phase_in = phase_ff;
      dir_in   = dir_ff;
      cnt_in   = cnt_ff;
      idle_in  = idle_ff;
      irq_in   = irq_ff;
      busy_in  = busy_ff;
      flush    = 1'b0;
      skip     = 1'b0;
      err      = 1'b0;
      case (req_data.opcode)
         OP_MOVE: begin
            if (!legal) begin
               err = 1'b1;
            end else begin
               phase_in = phase_eff;
               if (phase_eff == PH_SHOW) begin
                  if (d == dir_ff) begin
                     if (cnt_ff != CNT_MAX) begin
                        cnt_in = cnt_ff + COUNT_BITS'(1);
                     end
                  end else begin
                     flush  = 1'b1;
                     dir_in = d;
                     cnt_in = '0;
                  end
               end
               x_in = x_mv;
               if (phase_eff == PH_LIMIT && new_limit) begin
                  phase_in = PH_UNLIMIT;
               end else if (phase_eff == PH_UNLIMIT && !new_limit) begin
                  phase_in = PH_SHOW;
               end
               idle_in = 1'b0;
               busy_in = pen ? pen_ticks_ff : step_ticks_ff;
            end
         end
         OP_SKIP: begin
            case (req_data.device_bits[8:6])
               TST_IDLE:      skip = idle_ff;
               TST_NOT_LIMIT: skip = !cur_limit;
               TST_NO_IRQ:    skip = !(idle_ff && irq_ff);
               default:       err  = 1'b1;
            endcase
         end
         OP_MASK: begin
            irq_in = req_data.mask_bit;
         end
         OP_TICK: begin
            if (!idle_ff) begin
               if (busy_ff <= 16'd1) begin
                  busy_in = '0;
                  idle_in = 1'b1;
               end else begin
                  busy_in = busy_ff - 16'd1;
               end
            end
         end
         OP_CLEAR: begin
            flush    = 1'b1;
            dir_in   = DIR_NONE;
            cnt_in   = '0;
            phase_in = PH_LIMIT;
            irq_in   = 1'b0;
            idle_in  = 1'b1;
            busy_in  = '0;
         end
         default: begin
         end
      endcase
   end

   assign status.skip = skip;
   assign status.irq  = idle_in && irq_in;
   assign status.err  = err;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff     <= START_X_RESET;
         phase_ff <= PH_LIMIT;
         dir_ff   <= DIR_NONE;
         cnt_ff   <= '0;
         idle_ff  <= 1'b1;
         irq_ff   <= 1'b0;
         busy_ff  <= '0;
      end else if (accept) begin
         x_ff     <= x_in;
         phase_ff <= phase_in;
         dir_ff   <= dir_in;
         cnt_ff   <= cnt_in;
         idle_ff  <= idle_in;
         irq_ff   <= irq_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff    <= X_LIMIT_RESET;
         step_ticks_ff <= STEP_TICKS_RESET;
         pen_ticks_ff  <= PEN_TICKS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_X_LIMIT:    x_limit_ff    <= csr_wdata[14:0];
            CSR_STEP_TICKS: step_ticks_ff <= csr_wdata;
            CSR_PEN_TICKS:  pen_ticks_ff  <= csr_wdata;
            default: begin
               // start_x only matters at reset
            end
         endcase
      end
   end

   psrle_emit #(
      .COUNT_BITS (COUNT_BITS)
   ) u_emit (
      .clock        (clock),
      .reset        (reset),
      .ld           (accept),
      .ld_has_bytes (flush && (dir_ff != DIR_NONE)),
      .ld_cnt       (cnt_ff),
      .ld_dir       (dir_ff),
      .ld_status    (status),
      .ready        (emit_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

`ifndef SYNTH
   a_idle_not_busy: assert property (@(posedge clock) disable iff (reset)
      idle_ff |-> (busy_ff == '0))
      else $error("idle with busy ticks left");

   a_no_run_no_count: assert property (@(posedge clock) disable iff (reset)
      (dir_ff == DIR_NONE) |-> (cnt_ff == '0))
      else $error("run count without a run");

   a_run_only_showing: assert property (@(posedge clock) disable iff (reset)
      (dir_ff != DIR_NONE) |-> (phase_ff == PH_SHOW))
      else $error("open run outside the show phase");

   a_clear_empties_run: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.opcode == OP_CLEAR) |=> (dir_ff == DIR_NONE && idle_ff))
      else $error("master clear left a run open");
`endif

endmodule

`default_nettype wire
